/* rtl/core/capsule_sphere_collision_defines.svh */
// ----------------------------------------------------------------------------
// capsule sphere collision assertion macros
// immediate-free concurrent check helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef CAPSULE_SPHERE_COLLISION_DEFINES_SVH
`define CAPSULE_SPHERE_COLLISION_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CSC_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csc assertion failed");
// next-cycle implication
`define CSC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csc assertion failed");
`else
`define CSC_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define CSC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/csc_pkg.sv */
// ----------------------------------------------------------------------------
// csc_pkg
// shared types and constants of the capsule sphere collision block
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  localparam int COORD_WIDTH = 32;

  typedef enum logic [1:0] {
    REGION_BOTTOM = 2'd0,
    REGION_AXIS   = 2'd1,
    REGION_TOP    = 2'd2,
    REGION_POINT  = 2'd3
  } region_t;

  // control that rides along the multiplier stages
  typedef struct packed {
    logic    valid;
    region_t region;
    logic    hit_end;
    logic    e_neg;
  } side_t;

endpackage

`default_nettype wire

/* rtl/core/csc_if.sv */
// ----------------------------------------------------------------------------
// csc channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface csc_in_if #(
  parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] bottom_x;
  logic signed [COORD_WIDTH-1:0] bottom_y;
  logic signed [COORD_WIDTH-1:0] bottom_z;
  logic signed [COORD_WIDTH-1:0] top_x;
  logic signed [COORD_WIDTH-1:0] top_y;
  logic signed [COORD_WIDTH-1:0] top_z;
  logic        [COORD_WIDTH-2:0] capsule_radius;
  logic signed [COORD_WIDTH-1:0] sphere_x;
  logic signed [COORD_WIDTH-1:0] sphere_y;
  logic signed [COORD_WIDTH-1:0] sphere_z;
  logic        [COORD_WIDTH-2:0] sphere_radius;

  modport source (
    output valid, bottom_x, bottom_y, bottom_z, top_x, top_y, top_z,
           capsule_radius, sphere_x, sphere_y, sphere_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, bottom_x, bottom_y, bottom_z, top_x, top_y, top_z,
           capsule_radius, sphere_x, sphere_y, sphere_z, sphere_radius,
    output ready
  );
endinterface

interface csc_out_if ();
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] region;

  modport source (output valid, hit, region, input ready);
  modport sink (input valid, hit, region, output ready);
endinterface

`default_nettype wire

/* rtl/core/csc_wide_mul.sv */
// ----------------------------------------------------------------------------
// csc_wide_mul
// unsigned wide multiplier, split in half-width partial products, 3 stages
// ----------------------------------------------------------------------------
`default_nettype none

module csc_wide_mul #(
  parameter int AW = 66
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [AW-1:0]   a,
  input  wire logic [AW-1:0]   b,
  output logic      [2*AW-1:0] p
);
  localparam int H = (AW + 1) / 2;
  localparam int L = AW - H;

  logic [2*H-1:0]   ll_r, ll_nxt;
  logic [H+L-1:0]   lh_r, lh_nxt, hl_r, hl_nxt;
  logic [2*L-1:0]   hh_r, hh_nxt;
  logic [H+L:0]     mid_r, mid_nxt;
  logic [2*AW-1:0]  cat_r, cat_nxt;
  logic [2*AW-1:0]  p_r, p_nxt;

  always_comb begin
    ll_nxt  = a[H-1:0] * b[H-1:0];
    lh_nxt  = (H+L)'(a[H-1:0]) * (H+L)'(b[AW-1:H]);
    hl_nxt  = (H+L)'(a[AW-1:H]) * (H+L)'(b[H-1:0]);
    hh_nxt  = a[AW-1:H] * b[AW-1:H];
    mid_nxt = (H+L+1)'(lh_r) + (H+L+1)'(hl_r);
    cat_nxt = {hh_r, ll_r};
    p_nxt   = cat_r + ((2*AW)'(mid_r) << H);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= ll_nxt;
      lh_r  <= lh_nxt;
      hl_r  <= hl_nxt;
      hh_r  <= hh_nxt;
      mid_r <= mid_nxt;
      cat_r <= cat_nxt;
      p_r   <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

/* rtl/core/csc_front.sv */
// ----------------------------------------------------------------------------
// csc_front
// differences, dot products and region choice, 4 stages
// ----------------------------------------------------------------------------
`default_nettype none

module csc_front #(
  parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [COORD_WIDTH-1:0] bot_x,
  input  wire logic signed [COORD_WIDTH-1:0] bot_y,
  input  wire logic signed [COORD_WIDTH-1:0] bot_z,
  input  wire logic signed [COORD_WIDTH-1:0] top_x,
  input  wire logic signed [COORD_WIDTH-1:0] top_y,
  input  wire logic signed [COORD_WIDTH-1:0] top_z,
  input  wire logic        [COORD_WIDTH-2:0] cap_rad,
  input  wire logic signed [COORD_WIDTH-1:0] sph_x,
  input  wire logic signed [COORD_WIDTH-1:0] sph_y,
  input  wire logic signed [COORD_WIDTH-1:0] sph_z,
  input  wire logic        [COORD_WIDTH-2:0] sph_rad,
  output csc_pkg::side_t                     side_o,
  output logic             [2*COORD_WIDTH+1:0] e_mag_o,
  output logic             [2*COORD_WIDTH+1:0] dd_o,
  output logic             [2*COORD_WIDTH+1:0] dp_mag_o
);
  localparam int W = COORD_WIDTH;
  localparam int Q = 2 * W + 2;

  logic signed [W-1:0] bot [3];
  logic signed [W-1:0] top [3];
  logic signed [W-1:0] sph [3];

  // stage 1
  logic               v1_r;
  logic signed [W:0]  d_r [3], d_nxt [3];
  logic signed [W:0]  v_r [3], v_nxt [3];
  logic signed [W:0]  w_r [3], w_nxt [3];
  logic [W-1:0]       rsum_r, rsum_nxt;
  // stage 2
  logic               v2_r;
  logic [2*W-1:0]     ddk_r [3], ddk_nxt [3];
  logic signed [2*W:0] dvk_r [3], dvk_nxt [3];
  logic [2*W-1:0]     vvk_r [3], vvk_nxt [3];
  logic [2*W-1:0]     wwk_r [3], wwk_nxt [3];
  logic [2*W-1:0]     rr2_r, rr2_nxt;
  // stage 3
  logic               v3_r;
  logic [Q-1:0]       dd_r, dd_nxt, vv_r, vv_nxt, ww_r, ww_nxt;
  logic signed [Q:0]  dp_r, dp_nxt;
  logic [2*W-1:0]     rr3_r;
  // stage 4
  csc_pkg::side_t     side_r, side_nxt;
  logic [Q-1:0]       e_mag_r, e_mag_nxt, dd4_r, dp_mag_r, dp_mag_nxt;

  logic signed [2*W+1:0] sq_d, sq_v, sq_w, pr_dv;
  logic [Q:0]            e_full;
  logic                  dp_neg, dd_lt_dp;

  always_comb begin
    bot[0] = bot_x; bot[1] = bot_y; bot[2] = bot_z;
    top[0] = top_x; top[1] = top_y; top[2] = top_z;
    sph[0] = sph_x; sph[1] = sph_y; sph[2] = sph_z;
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = (W+1)'(top[k]) - (W+1)'(bot[k]);
      v_nxt[k] = (W+1)'(sph[k]) - (W+1)'(bot[k]);
      w_nxt[k] = (W+1)'(sph[k]) - (W+1)'(top[k]);
    end
    rsum_nxt = W'(cap_rad) + W'(sph_rad);
  end

  always_comb begin
    sq_d = '0; sq_v = '0; sq_w = '0; pr_dv = '0;
    for (int k = 0; k < 3; k++) begin
      sq_d       = (2*W+2)'(d_r[k]) * (2*W+2)'(d_r[k]);
      sq_v       = (2*W+2)'(v_r[k]) * (2*W+2)'(v_r[k]);
      sq_w       = (2*W+2)'(w_r[k]) * (2*W+2)'(w_r[k]);
      pr_dv      = (2*W+2)'(d_r[k]) * (2*W+2)'(v_r[k]);
      ddk_nxt[k] = sq_d[2*W-1:0];
      vvk_nxt[k] = sq_v[2*W-1:0];
      wwk_nxt[k] = sq_w[2*W-1:0];
      dvk_nxt[k] = pr_dv[2*W:0];
    end
    rr2_nxt = rsum_r * rsum_r;
  end

  always_comb begin
    dd_nxt = Q'(ddk_r[0]) + Q'(ddk_r[1]) + Q'(ddk_r[2]);
    vv_nxt = Q'(vvk_r[0]) + Q'(vvk_r[1]) + Q'(vvk_r[2]);
    ww_nxt = Q'(wwk_r[0]) + Q'(wwk_r[1]) + Q'(wwk_r[2]);
    dp_nxt = (Q+1)'(dvk_r[0]) + (Q+1)'(dvk_r[1]) + (Q+1)'(dvk_r[2]);
  end

  always_comb begin
    dp_neg   = dp_r[Q];
    dd_lt_dp = !dp_neg && (dd_r < dp_r[Q-1:0]);
    e_full   = (Q+1)'(vv_r) - (Q+1)'(rr3_r);
    side_nxt.valid = v3_r;
    priority if (dd_r == '0) side_nxt.region = csc_pkg::REGION_POINT;
    else if (dp_neg)         side_nxt.region = csc_pkg::REGION_BOTTOM;
    else if (dd_lt_dp)       side_nxt.region = csc_pkg::REGION_TOP;
    else                     side_nxt.region = csc_pkg::REGION_AXIS;
    if (side_nxt.region == csc_pkg::REGION_TOP) side_nxt.hit_end = ww_r < Q'(rr3_r);
    else                                         side_nxt.hit_end = vv_r < Q'(rr3_r);
    side_nxt.e_neg = e_full[Q];
    e_mag_nxt  = e_full[Q-1:0];
    dp_mag_nxt = dp_r[Q-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      side_r.valid <= 1'b0;
    end else if (en) begin
      v1_r         <= in_valid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      side_r.valid <= side_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r      <= d_nxt;
      v_r      <= v_nxt;
      w_r      <= w_nxt;
      rsum_r   <= rsum_nxt;
      ddk_r    <= ddk_nxt;
      dvk_r    <= dvk_nxt;
      vvk_r    <= vvk_nxt;
      wwk_r    <= wwk_nxt;
      rr2_r    <= rr2_nxt;
      dd_r     <= dd_nxt;
      vv_r     <= vv_nxt;
      ww_r     <= ww_nxt;
      dp_r     <= dp_nxt;
      rr3_r    <= rr2_r;
      side_r.region  <= side_nxt.region;
      side_r.hit_end <= side_nxt.hit_end;
      side_r.e_neg   <= side_nxt.e_neg;
      e_mag_r  <= e_mag_nxt;
      dd4_r    <= dd_r;
      dp_mag_r <= dp_mag_nxt;
    end
  end

  assign side_o   = side_r;
  assign e_mag_o  = e_mag_r;
  assign dd_o     = dd4_r;
  assign dp_mag_o = dp_mag_r;

endmodule

`default_nettype wire

/* rtl/core/capsule_sphere_collision.sv */
// path: an accepted request passes the front stages, the multiplier stages and then the output register
// throughput: one request per cycle; the whole pipeline advances together
// and holds while a result waits on a stalled output
// reset: synchronous active-low rst_n clears all stage valid bits and the output valid
// ----------------------------------------------------------------------------
// capsule_sphere_collision
// capsule against sphere overlap test with exact cross-multiplied compare
// ----------------------------------------------------------------------------
`default_nettype none

`include "capsule_sphere_collision_defines.svh"

module capsule_sphere_collision #(
  parameter int COORD_WIDTH = csc_pkg::COORD_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  csc_in_if.sink    in_req,
  csc_out_if.source out_res
);
  localparam int Q = 2 * COORD_WIDTH + 2;

  // single pipeline enable: move when the output slot is free or being taken
  logic adv;

  csc_pkg::side_t front_side;
  logic [Q-1:0]   e_mag, dd, dp_mag;
  logic [2*Q-1:0] lhs, rhs;

  // side band matching the three multiplier stages
  csc_pkg::side_t side_q [3];

  logic            out_valid_r;
  logic            out_hit_r, out_hit_nxt;
  csc_pkg::region_t out_region_r;

  assign adv          = !out_valid_r || out_res.ready;
  assign in_req.ready = adv;

  // stages 1 to 4: differences, products, dot sums, region and end tests
  csc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_req.valid),
    .bot_x    (in_req.bottom_x),
    .bot_y    (in_req.bottom_y),
    .bot_z    (in_req.bottom_z),
    .top_x    (in_req.top_x),
    .top_y    (in_req.top_y),
    .top_z    (in_req.top_z),
    .cap_rad  (in_req.capsule_radius),
    .sph_x    (in_req.sphere_x),
    .sph_y    (in_req.sphere_y),
    .sph_z    (in_req.sphere_z),
    .sph_rad  (in_req.sphere_radius),
    .side_o   (front_side),
    .e_mag_o  (e_mag),
    .dd_o     (dd),
    .dp_mag_o (dp_mag)
  );

  // stages 5 to 7: (|v|^2 - rr) * dd and dp^2, only meaningful along the axis
  csc_wide_mul #(.AW(Q)) u_mul_lhs (
    .clk (clk),
    .en  (adv),
    .a   (e_mag),
    .b   (dd),
    .p   (lhs)
  );

  csc_wide_mul #(.AW(Q)) u_mul_rhs (
    .clk (clk),
    .en  (adv),
    .a   (dp_mag),
    .b   (dp_mag),
    .p   (rhs)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) side_q[i].valid <= 1'b0;
    end else if (adv) begin
      side_q[0] <= front_side;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
    end
  end

  // along the axis: a negative |v|^2 - rr always hits, else compare products
  always_comb begin
    if (side_q[2].region == csc_pkg::REGION_AXIS) begin
      out_hit_nxt = side_q[2].e_neg || (lhs < rhs);
    end else begin
      out_hit_nxt = side_q[2].hit_end;
    end
  end

  // stage 8: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= side_q[2].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r    <= out_hit_nxt;
      out_region_r <= side_q[2].region;
    end
  end

  assign out_res.valid  = out_valid_r;
  assign out_res.hit    = out_hit_r;
  assign out_res.region = out_region_r;

  `CSC_ASSERT_NEXT(a_stall_holds_side, clk, rst_n, !adv, side_q[0] == $past(side_q[0]))
  `CSC_ASSERT_NEXT(a_axis_inside_hits, clk, rst_n, adv && side_q[2].valid && side_q[2].region == csc_pkg::REGION_AXIS && side_q[2].e_neg, out_hit_r)
  `CSC_ASSERT_IMPLY(a_out_from_pipe, clk, rst_n, $rose(out_valid_r), $past(side_q[2].valid))

endmodule

`default_nettype wire
